// ===== rtl/cfbc_pkg.sv =====
// ----------------------------------------------------------------------------
// cfbc_pkg
// Shared types and constants for the checksummed frame builder and chunker.
// ----------------------------------------------------------------------------
package cfbc_pkg;

	localparam logic [7:0] FRAME_HEAD   = 8'hA5;
	localparam logic [7:0] FRAME_TAIL   = 8'h5A;
	localparam logic [6:0] CHUNK_RESET  = 7'd20;
	localparam logic [15:0] LEN_EXTRA   = 16'd2;
	localparam int         QUEUE_DEPTH  = 2;

	localparam logic OP_START   = 1'b0;
	localparam logic OP_PAYLOAD = 1'b1;

	typedef logic [3:0] step_t;

	// byte positions of a frame as the back end walks it
	localparam step_t STEP_HEAD   = 4'd0;
	localparam step_t STEP_CTL    = 4'd1;
	localparam step_t STEP_SEQ    = 4'd2;
	localparam step_t STEP_LEN_LO = 4'd3;
	localparam step_t STEP_LEN_HI = 4'd4;
	localparam step_t STEP_CMD_LO = 4'd5;
	localparam step_t STEP_CMD_HI = 4'd6;
	localparam step_t STEP_SUM    = 4'd7;
	localparam step_t STEP_TAIL   = 4'd8;
	// a payload byte reuses the last header slot, STEP_CMD_HI
	localparam step_t DATA_BASE   = 4'd6;

	typedef enum logic {
		CMD_START,
		CMD_DATA
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic        last;     // start: empty payload; data: final payload byte
		logic [7:0]  ctl;
		logic [7:0]  seq;
		logic [15:0] cmd;
		logic [15:0] lenf;
		logic [7:0]  data;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t head;
	} q_head_t;

endpackage

// ===== rtl/cfbc_in_if.sv =====
// ----------------------------------------------------------------------------
// cfbc_in_if
// Input item channel: start items and payload bytes.
// ----------------------------------------------------------------------------
interface cfbc_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [7:0]  control_code;
	logic [7:0]  sequence_number;
	logic [15:0] command_code;
	logic [15:0] payload_length;
	logic [7:0]  payload_byte;

	modport source (
		output valid, opcode, control_code, sequence_number, command_code,
		       payload_length, payload_byte,
		input  ready
	);
	modport sink (
		input  valid, opcode, control_code, sequence_number, command_code,
		       payload_length, payload_byte,
		output ready
	);
endinterface

// ===== rtl/cfbc_out_if.sv =====
// ----------------------------------------------------------------------------
// cfbc_out_if
// Output byte channel with chunk and frame markers.
// ----------------------------------------------------------------------------
interface cfbc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       chunk_end;
	logic       frame_end;

	modport source (
		output valid, out_byte, chunk_end, frame_end,
		input  ready
	);
	modport sink (
		input  valid, out_byte, chunk_end, frame_end,
		output ready
	);
endinterface

// ===== rtl/cfbc_front.sv =====
// ----------------------------------------------------------------------------
// cfbc_front
// Accepts input words, tracks the open frame and turns each word into a
// command for the back end. Stray payload bytes are dropped here.
// ----------------------------------------------------------------------------
module cfbc_front
	import cfbc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	cfbc_in_if.sink    item,
	input  logic       q_full,
	output logic       push,
	output cmd_t       push_cmd
);

	logic        open_q;
	logic [15:0] remaining_q;
	logic        accept;

	assign item.ready = !q_full;
	assign accept     = item.valid && item.ready;

	always_comb begin
		push_cmd.ctl  = item.control_code;
		push_cmd.seq  = item.sequence_number;
		push_cmd.cmd  = item.command_code;
		push_cmd.lenf = item.payload_length + LEN_EXTRA;
		push_cmd.data = item.payload_byte;
		if (item.opcode == OP_START) begin
			push_cmd.kind = CMD_START;
			push_cmd.last = (item.payload_length == 16'd0);
			push          = accept;
		end else begin
			push_cmd.kind = CMD_DATA;
			push_cmd.last = (remaining_q == 16'd1);
			push          = accept && open_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= 1'b0;
			remaining_q <= 16'd0;
		end else if (push) begin
			if (push_cmd.kind == CMD_START) begin
				open_q      <= !push_cmd.last;
				remaining_q <= item.payload_length;
			end else begin
				open_q      <= !push_cmd.last;
				remaining_q <= remaining_q - 16'd1;
			end
		end
	end

endmodule

// ===== rtl/cfbc_queue.sv =====
// ----------------------------------------------------------------------------
// cfbc_queue
// Small command FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module cfbc_queue
	import cfbc_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output logic    full,
	output q_head_t status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full        = (count_q == FULL_CNT);
	assign status.valid = (count_q != '0);
	assign status.head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/cfbc_back.sv =====
// ----------------------------------------------------------------------------
// cfbc_back
// Walks each queued command byte by byte, keeps the running sum and the
// chunk position, and drives the registered output channel.
// ----------------------------------------------------------------------------
module cfbc_back
	import cfbc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [6:0] chunk_size,
	input  q_head_t    status,
	output logic       pop,
	cfbc_out_if.source stream
);

	step_t      step_q;
	logic [7:0] sum_q;
	logic [6:0] pos_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       chunk_q;
	logic       frame_q;

	step_t      eff;
	logic       adv;
	logic       done;
	logic       first;
	logic       last_byte;
	logic       close;
	logic [7:0] b;
	logic [7:0] sum_base;
	logic [6:0] pos_next;
	cmd_t       h;

	assign h    = status.head;
	assign eff  = (h.kind == CMD_DATA) ? step_q + DATA_BASE : step_q;
	assign adv  = status.valid && (!valid_q || stream.ready);
	assign done = (eff == STEP_TAIL) || ((eff == STEP_CMD_HI) && !h.last);
	assign pop  = adv && done;

	assign first     = (h.kind == CMD_START) && (eff == STEP_HEAD);
	assign last_byte = (eff == STEP_TAIL);
	assign sum_base  = first ? 8'd0 : sum_q;
	assign pos_next  = (first ? 7'd0 : pos_q) + 7'd1;
	assign close     = last_byte || (pos_next >= chunk_size) || (pos_next == 7'd0);

	always_comb begin
		unique case (eff)
			STEP_HEAD:   b = FRAME_HEAD;
			STEP_CTL:    b = h.ctl;
			STEP_SEQ:    b = h.seq;
			STEP_LEN_LO: b = h.lenf[7:0];
			STEP_LEN_HI: b = h.lenf[15:8];
			STEP_CMD_LO: b = h.cmd[7:0];
			STEP_CMD_HI: b = (h.kind == CMD_START) ? h.cmd[15:8] : h.data;
			STEP_SUM:    b = sum_q;
			STEP_TAIL:   b = FRAME_TAIL;
			default:     b = FRAME_TAIL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_HEAD;
			sum_q   <= 8'd0;
			pos_q   <= 7'd0;
			valid_q <= 1'b0;
		end else begin
			if (adv) begin
				step_q  <= done ? STEP_HEAD : step_q + 4'd1;
				sum_q   <= sum_base + b;
				pos_q   <= close ? 7'd0 : pos_next;
				valid_q <= 1'b1;
			end else if (stream.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q  <= b;
			chunk_q <= close;
			frame_q <= last_byte;
		end
	end

	assign stream.valid     = valid_q;
	assign stream.out_byte  = byte_q;
	assign stream.chunk_end = chunk_q;
	assign stream.frame_end = frame_q;

endmodule

// ===== rtl/checksummed_frame_builder_chunker.sv =====
// ----------------------------------------------------------------------------
// checksummed_frame_builder_chunker
// Frame builder with 8-bit checksum and link-packet chunk marking.
// ----------------------------------------------------------------------------
// Channels: item takes start words (opcode 0, header fields) and payload
// bytes (opcode 1); stream gives framed bytes with chunk_end and frame_end.
// cfg_we/cfg_wdata write chunk_size (reset 20); the user must write it only
// while idle, as the block does not enforce it. A start word yields 7
// header bytes, or 9 with sum and trailer when the payload is empty; the
// last payload byte yields 3 bytes, any other 1. A word's first byte passes
// the command queue, then the output register. Throughput: while the
// receiver is ready, the back end emits one byte per cycle, so payload
// streams at one word per cycle; a start word holds the back end for its
// header bytes, and the command queue (QDEPTH entries) lets the front keep
// taking words meanwhile until it fills. Payload bytes with no open frame
// are dropped by the front end. Reset clears the open frame, the queue and
// the output register. When the receiver stalls, the output register holds
// its byte, the back end waits, and item.ready falls once the queue is full.
// ----------------------------------------------------------------------------
module checksummed_frame_builder_chunker
	import cfbc_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	cfbc_in_if.sink    item,
	cfbc_out_if.source stream
);

	logic [6:0] chunk_q;
	logic       push;
	cmd_t       push_cmd;
	logic       full;
	logic       pop;
	q_head_t    status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			chunk_q <= CHUNK_RESET;
		else if (cfg_we)
			chunk_q <= cfg_wdata;
	end

	cfbc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.q_full   (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	cfbc_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (full),
		.status   (status)
	);

	cfbc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.chunk_size (chunk_q),
		.status     (status),
		.pop        (pop),
		.stream     (stream)
	);

endmodule
